/* sv/direct_sum_gravity_force_macros.svh */
// Assertion macros shared by the gravity force RTL.
// Expects signals named clk and arst_n in the scope of use.
`ifndef DIRECT_SUM_GRAVITY_FORCE_MACROS_SVH
`define DIRECT_SUM_GRAVITY_FORCE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define DSGF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define DSGF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/dsgf_pkg.sv */
// Types, widths and helpers for the direct-sum gravity force block.
// No dependencies; imported by every module of the block.
`default_nettype none

package dsgf_pkg;

	// Operand and product widths of the shared multiplier lanes
	localparam int LW = 33;
	localparam int PW = 66;
	// Sum of squared distances and its integer root
	localparam int SW = 66;
	localparam int RTW = 33;
	// Divider: remainder/divisor width and quotient register width
	localparam int DRW = 66;
	localparam int QW = 80;
	localparam int STEPW = 7;
	// Component numerator (64-bit quotient times 33-bit distance)
	localparam int NW = 97;
	// Accumulators: force and energy, wide enough for the largest table
	localparam int FW = 82;
	localparam int EW = 98;

	localparam logic [STEPW-1:0] STEPS_64 = 7'd64;
	localparam logic [STEPW-1:0] STEPS_80 = 7'd80;

	// Commands
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Register indexes
	localparam logic [1:0] REG_STAR_COUNT = 2'd0;
	localparam logic [1:0] REG_GRAV_TIMES_TEST_MASS = 2'd1;
	localparam logic [1:0] REG_TEST_MASS = 2'd2;

	// One table entry
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [31:0] m;
	} star_t;

	// Divider request
	typedef struct packed {
		logic start;
		logic [STEPW-1:0] steps;
	} div_ctl_t;

	// Clip a wide signed value to 64 bits; the top bit flags clipping
	function automatic logic [64:0] sat_clip(input logic [EW-1:0] a);
		logic hi_ones;
		logic hi_zeros;
		hi_ones = &a[EW-1:63];
		hi_zeros = ~|a[EW-1:63];
		if (hi_ones || hi_zeros)
			return {1'b0, a[63:0]};
		else if (a[EW-1])
			return {1'b1, 64'h8000_0000_0000_0000};
		else
			return {1'b1, 64'h7FFF_FFFF_FFFF_FFFF};
	endfunction

endpackage

`default_nettype wire

/* sv/direct_sum_gravity_force.sv */
// Direct-sum gravity force on a test star.
// Depends on dsgf_pkg, dsgf_div, dsgf_isqrt and the assertion macro header.
//
// Usage:
//  - Input channel (in_valid/in_stall): cmd 0 writes one field star
//    (pos_x/y/z, star_mass) to entry star_index, with no result.
//    cmd 1 is a query: pos_x/y/z and vel_x/y/z of the test star.
//  - A query walks table entries 0..star_count-1 (capped at MAX_STARS) and
//    returns force_x/y/z, total_energy and saturated on the output channel.
//  - Timing: setup of the kinetic term, then one pass per star at non-zero
//    distance (a star at zero distance is skipped early), then a clip step. The 64-step
//    quotient divider and the 80-step potential divider set the per-star time.
//  - in_stall is high from query acceptance until its result is registered;
//    loads are taken one per cycle otherwise, also while a result waits.
//  - A result waiting under out_stall holds; a finished query then waits
//    for the output register to free.
//  - Reset clears control and the registers (star_count 1024, both masses
//    1.0); table contents are undefined until loaded. No clearing pass.
//  - Configuration writes (cfg_we) are to be issued only while the block is idle.
`default_nettype none

module direct_sum_gravity_force
	import dsgf_pkg::*;
#(
	parameter int MAX_STARS = 1024
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic cmd,
	input  wire logic [9:0] star_index,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] pos_z,
	input  wire logic [31:0] star_mass,
	input  wire logic signed [31:0] vel_x,
	input  wire logic signed [31:0] vel_y,
	input  wire logic signed [31:0] vel_z,
	output logic out_valid,
	input  wire logic out_stall,
	output logic signed [63:0] force_x,
	output logic signed [63:0] force_y,
	output logic signed [63:0] force_z,
	output logic signed [63:0] total_energy,
	output logic saturated
);

`include "direct_sum_gravity_force_macros.svh"

	localparam int AW = (MAX_STARS > 1) ? $clog2(MAX_STARS) : 1;
	localparam int CW = $clog2(MAX_STARS + 1);
	localparam int XW = (AW > 10) ? AW : 10;

	typedef enum logic [4:0] {
		ST_IDLE, ST_VSQ, ST_VSUM, ST_KMUL, ST_KFIN,
		ST_RD, ST_DIFF, ST_SQ, ST_SUM, ST_START, ST_ROOT,
		ST_CM0, ST_CM1, ST_CM2, ST_DSTART, ST_DWAIT, ST_ACC, ST_CLIP
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [10:0] star_count_q;
	logic [31:0] gtm_q;
	logic [31:0] tm_q;

	// Table and its ports
	star_t mem [MAX_STARS];
	star_t rd_q;
	star_t wr_data;
	logic mem_we;
	logic mem_re;
	logic [XW-1:0] ld_idx;
	logic in_take;

	// Sequencing
	logic [CW-1:0] idx_q;
	logic [CW-1:0] n_q;
	logic last_star;

	// Query operands
	logic [31:0] p_q [3];
	logic [31:0] v_q [3];
	logic [31:0] vmag [3];
	logic [63:0] vsum_q;

	// Per-star datapath
	logic [31:0] tab [3];
	logic [32:0] diff [3];
	logic [LW-1:0] ad_q [3];
	logic neg_q [3];
	logic [31:0] mass_q;
	logic [SW-1:0] s_q;
	logic [63:0] gm_q;
	logic qsat_q;
	logic [RTW-1:0] r_q;
	logic [63:0] qv_q;
	logic [PW-1:0] plo_q [3];
	logic [NW-1:0] num_q [3];
	logic [95:0] kin;

	// Multiplier lanes
	logic [LW-1:0] la [3];
	logic [LW-1:0] lb [3];
	logic [PW-1:0] prod [3];
	logic [PW-1:0] mp_q [3];

	// Accumulators
	logic [FW-1:0] f_q [3];
	logic [EW-1:0] en_q;
	logic sat_q;

	// Iterative units
	logic unit_go;
	logic sq_busy;
	logic [RTW-1:0] sq_root;
	div_ctl_t qd_ctl;
	div_ctl_t cd_ctl;
	div_ctl_t pd_ctl;
	logic qd_busy;
	logic [QW-1:0] qd_quo;
	logic [2:0] comp_busy;
	logic [QW-1:0] comp_quo [3];
	logic pot_busy;
	logic [QW-1:0] pot_quo;

	// Output register
	logic [64:0] clip_r [4];
	logic out_valid_q;
	logic [63:0] fx_out_q;
	logic [63:0] fy_out_q;
	logic [63:0] fz_out_q;
	logic [63:0] en_out_q;
	logic sat_out_q;

	assign in_stall = (state_q != ST_IDLE);
	assign in_take = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign force_x = fx_out_q;
	assign force_y = fy_out_q;
	assign force_z = fz_out_q;
	assign total_energy = en_out_q;
	assign saturated = sat_out_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			star_count_q <= 11'd1024;
			gtm_q <= 32'd65536;
			tm_q <= 32'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STAR_COUNT: star_count_q <= cfg_data[10:0];
				REG_GRAV_TIMES_TEST_MASS: gtm_q <= cfg_data;
				REG_TEST_MASS: tm_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Table: loads only in idle, reads only during a query, so no overlap
	assign ld_idx = XW'(star_index);
	assign mem_we = in_take && (cmd == CMD_LOAD) && (32'(star_index) < MAX_STARS);
	assign mem_re = (state_q == ST_RD);
	assign wr_data = '{x: pos_x, y: pos_y, z: pos_z, m: star_mass};

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[ld_idx[AW-1:0]] <= wr_data;
		if (mem_re)
			rd_q <= mem[idx_q[AW-1:0]];
	end

	// Velocity magnitudes and distance per axis
	assign tab[0] = rd_q.x;
	assign tab[1] = rd_q.y;
	assign tab[2] = rd_q.z;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			vmag[k] = v_q[k][31] ? (~v_q[k] + 32'd1) : v_q[k];
			diff[k] = {tab[k][31], tab[k]} - {p_q[k][31], p_q[k]};
		end
	end

	// Select lane operands by step
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			la[k] = '0;
			lb[k] = '0;
		end
		case (state_q)
			ST_VSQ: begin
				for (int k = 0; k < 3; k++) begin
					la[k] = LW'(vmag[k]);
					lb[k] = LW'(vmag[k]);
				end
			end
			ST_KMUL: begin
				la[0] = LW'(tm_q);
				lb[0] = LW'(vsum_q[31:0]);
				la[1] = LW'(tm_q);
				lb[1] = LW'(vsum_q[63:32]);
			end
			ST_SQ: begin
				for (int k = 0; k < 3; k++) begin
					la[k] = ad_q[k];
					lb[k] = ad_q[k];
				end
			end
			ST_SUM: begin
				la[0] = LW'(gtm_q);
				lb[0] = LW'(mass_q);
			end
			ST_CM0: begin
				for (int k = 0; k < 3; k++) begin
					la[k] = LW'(qv_q[31:0]);
					lb[k] = ad_q[k];
				end
			end
			ST_CM1: begin
				for (int k = 0; k < 3; k++) begin
					la[k] = LW'(qv_q[63:32]);
					lb[k] = ad_q[k];
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		for (int k = 0; k < 3; k++)
			prod[k] = la[k] * lb[k];
	end

	assign kin = (96'(mp_q[1][63:0]) << 32) + 96'(mp_q[0][63:0]);

	// Iterative units: root and force magnitude in parallel, then four divisions
	assign unit_go = (state_q == ST_START) && (s_q != '0);
	assign qd_ctl = '{start: unit_go, steps: STEPS_64};
	assign cd_ctl = '{start: (state_q == ST_DSTART), steps: STEPS_64};
	assign pd_ctl = '{start: (state_q == ST_DSTART), steps: STEPS_80};

	dsgf_isqrt u_isqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(unit_go),
		.s(s_q),
		.busy(sq_busy),
		.root(sq_root)
	);

	// gm * 2^32 / s, with the top 32 bits of gm as the starting remainder
	dsgf_div u_qdiv (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(qd_ctl),
		.rem0(DRW'(mp_q[0][63:32])),
		.num({mp_q[0][31:0], 48'd0}),
		.divisor(s_q),
		.busy(qd_busy),
		.quo(qd_quo)
	);

	for (genvar k = 0; k < 3; k++) begin : g_comp
		dsgf_div u_cdiv (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(cd_ctl),
			.rem0(DRW'(num_q[k][NW-1:64])),
			.num({num_q[k][63:0], 16'd0}),
			.divisor(DRW'(r_q)),
			.busy(comp_busy[k]),
			.quo(comp_quo[k])
		);
	end

	dsgf_div u_pdiv (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(pd_ctl),
		.rem0('0),
		.num({gm_q, 16'd0}),
		.divisor(DRW'(r_q)),
		.busy(pot_busy),
		.quo(pot_quo)
	);

	// Datapath registers
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++)
			mp_q[k] <= prod[k];
		if (in_take && (cmd == CMD_QUERY)) begin
			p_q[0] <= pos_x;
			p_q[1] <= pos_y;
			p_q[2] <= pos_z;
			v_q[0] <= vel_x;
			v_q[1] <= vel_y;
			v_q[2] <= vel_z;
		end
		case (state_q)
			ST_VSUM: vsum_q <= mp_q[0][63:0] + mp_q[1][63:0] + mp_q[2][63:0];
			ST_KFIN: begin
				en_q <= EW'(kin[95:17]);
				sat_q <= 1'b0;
				for (int k = 0; k < 3; k++)
					f_q[k] <= '0;
			end
			ST_DIFF: begin
				mass_q <= rd_q.m;
				for (int k = 0; k < 3; k++) begin
					neg_q[k] <= diff[k][32];
					ad_q[k] <= diff[k][32] ? (~diff[k] + 33'd1) : diff[k];
				end
			end
			ST_SUM: s_q <= mp_q[0] + mp_q[1] + mp_q[2];
			ST_START: begin
				gm_q <= mp_q[0][63:0];
				qsat_q <= (SW'(mp_q[0][63:32]) >= s_q);
			end
			ST_ROOT: begin
				r_q <= sq_root;
				qv_q <= qsat_q ? '1 : qd_quo[63:0];
				if (!sq_busy && !qd_busy)
					sat_q <= sat_q | qsat_q;
			end
			ST_CM1: begin
				for (int k = 0; k < 3; k++)
					plo_q[k] <= mp_q[k];
			end
			ST_CM2: begin
				for (int k = 0; k < 3; k++)
					num_q[k] <= (NW'(mp_q[k]) << 32) + NW'(plo_q[k]);
			end
			ST_ACC: begin
				for (int k = 0; k < 3; k++)
					f_q[k] <= neg_q[k] ? f_q[k] - FW'(comp_quo[k][63:0])
						: f_q[k] + FW'(comp_quo[k][63:0]);
				en_q <= en_q - EW'(pot_quo);
			end
			default: ;
		endcase
	end

	// Final clipping
	always_comb begin
		for (int k = 0; k < 3; k++)
			clip_r[k] = sat_clip({{(EW-FW){f_q[k][FW-1]}}, f_q[k]});
		clip_r[3] = sat_clip(en_q);
	end

	assign last_star = ((idx_q + CW'(1)) == n_q);

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			n_q <= '0;
			out_valid_q <= 1'b0;
			fx_out_q <= '0;
			fy_out_q <= '0;
			fz_out_q <= '0;
			en_out_q <= '0;
			sat_out_q <= 1'b0;
		end else begin
			// drop the result once transferred
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_take && (cmd == CMD_QUERY)) begin
						n_q <= (32'(star_count_q) > MAX_STARS) ? CW'(MAX_STARS)
							: CW'(star_count_q);
						state_q <= ST_VSQ;
					end
				end
				ST_VSQ: state_q <= ST_VSUM;
				ST_VSUM: state_q <= ST_KMUL;
				ST_KMUL: state_q <= ST_KFIN;
				ST_KFIN: begin
					idx_q <= '0;
					state_q <= (n_q == '0) ? ST_CLIP : ST_RD;
				end
				ST_RD: state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_SQ;
				ST_SQ: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_START;
				ST_START: begin
					// skip a star at zero distance
					if (s_q == '0) begin
						if (last_star) begin
							state_q <= ST_CLIP;
						end else begin
							idx_q <= idx_q + CW'(1);
							state_q <= ST_RD;
						end
					end else begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (!sq_busy && !qd_busy)
						state_q <= ST_CM0;
				end
				ST_CM0: state_q <= ST_CM1;
				ST_CM1: state_q <= ST_CM2;
				ST_CM2: state_q <= ST_DSTART;
				ST_DSTART: state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (!(|comp_busy) && !pot_busy)
						state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (last_star) begin
						state_q <= ST_CLIP;
					end else begin
						idx_q <= idx_q + CW'(1);
						state_q <= ST_RD;
					end
				end
				ST_CLIP: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						fx_out_q <= clip_r[0][63:0];
						fy_out_q <= clip_r[1][63:0];
						fz_out_q <= clip_r[2][63:0];
						en_out_q <= clip_r[3][63:0];
						sat_out_q <= sat_q | clip_r[0][64] | clip_r[1][64]
							| clip_r[2][64] | clip_r[3][64];
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`DSGF_ASSERT_IMP(a_no_rw_clash, mem_we, !mem_re, "table written and read in one cycle")
	`DSGF_ASSERT_IMP(a_rd_in_range, mem_re, idx_q < n_q, "table read beyond the active count")
	`DSGF_ASSERT_IMP(a_units_free, state_q == ST_START, !sq_busy && !qd_busy, "root unit busy at start")
	`DSGF_ASSERT_NXT(a_clip_done, (state_q == ST_CLIP) && (!out_valid_q || !out_stall), out_valid_q && (state_q == ST_IDLE), "finished query not presented")

endmodule

`default_nettype wire

/* sv/dsgf_div.sv */
// Restoring divider, one quotient bit per cycle, step count set per request.
// Depends on dsgf_pkg for widths and the request struct.
`default_nettype none

module dsgf_div
	import dsgf_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire div_ctl_t ctl,
	input  wire logic [DRW-1:0] rem0,
	input  wire logic [QW-1:0] num,
	input  wire logic [DRW-1:0] divisor,
	output logic busy,
	output logic [QW-1:0] quo
);

	logic [STEPW-1:0] cnt_q;
	logic [DRW-1:0] rem_q;
	logic [DRW-1:0] d_q;
	logic [QW-1:0] num_q;
	logic [QW-1:0] quo_q;
	logic [DRW:0] trial;
	logic [DRW:0] diff;
	logic ge;

	assign busy = (cnt_q != '0);
	assign quo = quo_q;

	// Shift in the next numerator bit and try the subtraction
	assign trial = {rem_q, num_q[QW-1]};
	assign diff = trial - {1'b0, d_q};
	assign ge = (trial >= {1'b0, d_q});

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.start) begin
			cnt_q <= ctl.steps;
		end else if (busy) begin
			cnt_q <= cnt_q - STEPW'(1);
		end
	end

	// Load operands, then advance one bit a cycle
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= rem0;
			d_q <= divisor;
			num_q <= num;
			quo_q <= '0;
		end else if (busy) begin
			rem_q <= ge ? diff[DRW-1:0] : trial[DRW-1:0];
			num_q <= {num_q[QW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

endmodule

`default_nettype wire

/* sv/dsgf_isqrt.sv */
// Integer square root, two radicand bits per cycle.
// Depends on dsgf_pkg for widths.
`default_nettype none

module dsgf_isqrt
	import dsgf_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [SW-1:0] s,
	output logic busy,
	output logic [RTW-1:0] root
);

	localparam int STEPS = SW / 2;
	localparam int CNTW = $clog2(STEPS + 1);
	localparam int REMW = RTW + 3;

	logic [CNTW-1:0] cnt_q;
	logic [SW-1:0] s_q;
	logic [REMW-1:0] rem_q;
	logic [RTW-1:0] root_q;
	logic [REMW+1:0] rem_n;
	logic [REMW+1:0] trial;
	logic ge;

	assign busy = (cnt_q != '0);
	assign root = root_q;

	// Bring down two bits and test root*4+1
	assign rem_n = {rem_q, s_q[SW-1:SW-2]};
	assign trial = (REMW+2)'({root_q, 2'b01});
	assign ge = (rem_n >= trial);

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNTW'(STEPS);
		end else if (busy) begin
			cnt_q <= cnt_q - CNTW'(1);
		end
	end

	// Digit-by-digit root
	always_ff @(posedge clk) begin
		if (start) begin
			s_q <= s;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy) begin
			s_q <= {s_q[SW-3:0], 2'b00};
			rem_q <= ge ? REMW'(rem_n - trial) : REMW'(rem_n);
			root_q <= {root_q[RTW-2:0], ge};
		end
	end

endmodule

`default_nettype wire

/* bench/direct_sum_gravity_force_tb.sv */
// Self-checking bench for direct_sum_gravity_force: drives loads and queries,
// predicts or states each query's force and energy, and checks every result transfer.
// Depends on dsgf_pkg and the direct_sum_gravity_force RTL.
`timescale 1ns / 100ps

module direct_sum_gravity_force_tb;
	import dsgf_pkg::*;

	localparam int TABLE_SIZE = 1024;
	localparam int PRELOAD_STARS = 8;
	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT = 700000;
	localparam int HOLD_CYCLES = 3000;
	localparam logic [31:0] Q_ONE = 32'h0001_0000;

	typedef struct {
		logic cmd;
		logic [9:0] idx;
		logic signed [31:0] px, py, pz;
		logic [31:0] m;
		logic signed [31:0] vx, vy, vz;
	} star_item_t;

	typedef struct {
		logic signed [63:0] fx, fy, fz, en;
		logic sat;
	} force_res_t;

	typedef struct {
		bit is_cfg;
		logic [1:0] reg_idx;
		logic [31:0] reg_val;
		star_item_t it;
		bit has_lit;
		force_res_t lit;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic cmd = CMD_LOAD;
	logic [9:0] star_index = '0;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic [31:0] star_mass = '0;
	logic signed [31:0] vel_x = '0, vel_y = '0, vel_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [63:0] force_x, force_y, force_z, total_energy;
	logic saturated;

	// Predictor state: table copy and register copies
	logic signed [31:0] tab_px[TABLE_SIZE], tab_py[TABLE_SIZE], tab_pz[TABLE_SIZE];
	logic [31:0] tab_mass[TABLE_SIZE];
	logic [10:0] sum_count = 11'd1024;
	logic [31:0] gm_reg = Q_ONE;
	logic [31:0] tmass_reg = Q_ONE;

	force_res_t pending_forces[$];
	int err_count = 0;
	int quiet_cycles = 0;
	bit hold_go = 1'b0;
	bit hold_taken = 1'b0;
	int stall_left = 0;

	direct_sum_gravity_force dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .star_index(star_index),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .star_mass(star_mass),
		.vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.force_x(force_x), .force_y(force_y), .force_z(force_z),
		.total_energy(total_energy), .saturated(saturated)
	);

	always #10 clk = ~clk;

	// Integer square root of a sum of squares below 2^68
	function automatic logic [127:0] root_floor(input logic [127:0] s);
		logic [127:0] res, c;
		res = '0;
		for (int b = 33; b >= 0; b--) begin
			c = res | (128'd1 << b);
			if (c * c <= s)
				res = c;
		end
		return res;
	endfunction

	// Clip to signed 64 bits, flagging any clip
	function automatic logic [63:0] clip_q32(input logic [127:0] a, inout logic sat);
		if (&a[127:63] || ~|a[127:63])
			return a[63:0];
		sat = 1'b1;
		return a[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
	endfunction

	function automatic logic [127:0] mag32(input logic signed [31:0] v);
		longint sv;
		sv = v;
		return (sv < 0) ? 128'(-sv) : 128'(sv);
	endfunction

	// Sum the pull of every active star on the test star, plus its energy
	function automatic force_res_t predict_force(input star_item_t it);
		logic [127:0] fx, fy, fz, en, s, q, gmw, r, ax, ay, az, vsq;
		logic [63:0] qv;
		longint dx, dy, dz;
		int n;
		force_res_t res;
		logic sat;
		sat = 1'b0;
		fx = '0;
		fy = '0;
		fz = '0;
		vsq = mag32(it.vx) * mag32(it.vx) + mag32(it.vy) * mag32(it.vy)
			+ mag32(it.vz) * mag32(it.vz);
		en = (128'(tmass_reg) * vsq) >> 17;
		n = (sum_count > TABLE_SIZE) ? TABLE_SIZE : int'(sum_count);
		for (int i = 0; i < n; i++) begin
			dx = longint'(tab_px[i]) - longint'(it.px);
			dy = longint'(tab_py[i]) - longint'(it.py);
			dz = longint'(tab_pz[i]) - longint'(it.pz);
			ax = (dx < 0) ? 128'(-dx) : 128'(dx);
			ay = (dy < 0) ? 128'(-dy) : 128'(dy);
			az = (dz < 0) ? 128'(-dz) : 128'(dz);
			s = ax * ax + ay * ay + az * az;
			if (s == 0)
				continue;
			r = root_floor(s);
			gmw = 128'(gm_reg) * 128'(tab_mass[i]);
			q = (gmw << 32) / s;
			if (q[127:64] != 0) begin
				qv = '1;
				sat = 1'b1;
			end else begin
				qv = q[63:0];
			end
			fx = (dx < 0) ? fx - (128'(qv) * ax) / r : fx + (128'(qv) * ax) / r;
			fy = (dy < 0) ? fy - (128'(qv) * ay) / r : fy + (128'(qv) * ay) / r;
			fz = (dz < 0) ? fz - (128'(qv) * az) / r : fz + (128'(qv) * az) / r;
			en = en - (gmw << 16) / r;
		end
		res.fx = clip_q32(fx, sat);
		res.fy = clip_q32(fy, sat);
		res.fz = clip_q32(fz, sat);
		res.en = clip_q32(en, sat);
		res.sat = sat;
		return res;
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] want,
			input logic [63:0] got);
		$display("%0t mismatch on %s: expected %h, got %h", $realtime, field, want, got);
		err_count++;
	endtask

	// Check each result transfer against the oldest expectation
	always @(posedge clk) begin
		force_res_t want;
		if (out_valid && !out_stall) begin
			if (pending_forces.size() == 0) begin
				report_mismatch("unexpected result", '0, force_x);
			end else begin
				want = pending_forces.pop_front();
				if (force_x !== want.fx) report_mismatch("force_x", want.fx, force_x);
				if (force_y !== want.fy) report_mismatch("force_y", want.fy, force_y);
				if (force_z !== want.fz) report_mismatch("force_z", want.fz, force_z);
				if (total_energy !== want.en)
					report_mismatch("total_energy", want.en, total_energy);
				if (saturated !== want.sat)
					report_mismatch("saturated", 64'(want.sat), 64'(saturated));
			end
		end
	end

	// Watchdog: end the run after too long without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		int pick;
		pick = $urandom_range(0, 99);
		if (hold_go && !hold_taken) begin
			hold_taken <= 1'b1;
			out_stall <= 1'b1;
			stall_left <= HOLD_CYCLES;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (pick < 55) begin
			out_stall <= 1'b0;
			stall_left <= $urandom_range(1, 30);
		end else if (pick < 93) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 4);
		end else begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(20, 120);
		end
	end

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 65) return 0;
		if (p < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one item, wait for its transfer, then update the predictor
	task automatic offer_item(input star_item_t it, input bit has_lit, input force_res_t lit);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		cmd <= it.cmd;
		star_index <= it.idx;
		pos_x <= it.px;
		pos_y <= it.py;
		pos_z <= it.pz;
		star_mass <= it.m;
		vel_x <= it.vx;
		vel_y <= it.vy;
		vel_z <= it.vz;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (it.cmd == CMD_QUERY) begin
			pending_forces.push_back(has_lit ? lit : predict_force(it));
		end else begin
			tab_px[it.idx] = it.px;
			tab_py[it.idx] = it.py;
			tab_pz[it.idx] = it.pz;
			tab_mass[it.idx] = it.m;
		end
	endtask

	// Drain the block, let it settle, then write one register
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_forces.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_STAR_COUNT: sum_count = val[10:0];
			REG_GRAV_TIMES_TEST_MASS: gm_reg = val;
			REG_TEST_MASS: tmass_reg = val;
			default: ;
		endcase
	endtask

	function automatic dir_row_t cfg_row(input logic [1:0] idx, input logic [31:0] val);
		dir_row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	function automatic dir_row_t load_row(input logic [9:0] idx, input logic [31:0] x,
			input logic [31:0] y, input logic [31:0] z, input logic [31:0] m);
		dir_row_t r;
		r = '{default: '0};
		r.it = '{CMD_LOAD, idx, x, y, z, m, '0, '0, '0};
		return r;
	endfunction

	function automatic dir_row_t query_row(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic [31:0] vx, input logic [31:0] vy,
			input logic [31:0] vz);
		dir_row_t r;
		r = '{default: '0};
		r.it = '{CMD_QUERY, '0, x, y, z, '0, vx, vy, vz};
		return r;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2, 3: return $urandom;
			default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
		endcase
	endfunction

	function automatic logic [31:0] rand_mass();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(0, 32'h0010_0000);
		endcase
	endfunction

	function automatic logic [31:0] rand_reg_mass();
		case ($urandom_range(0, 3))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return Q_ONE;
			default: return $urandom;
		endcase
	endfunction

	function automatic star_item_t rand_load(input int near_limit);
		star_item_t it;
		it.cmd = CMD_LOAD;
		it.idx = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(0, near_limit))
			: 10'($urandom_range(0, TABLE_SIZE - 1));
		it.px = rand_coord();
		it.py = rand_coord();
		it.pz = rand_coord();
		it.m = rand_mass();
		it.vx = $urandom;
		it.vy = $urandom;
		it.vz = $urandom;
		return it;
	endfunction

	function automatic star_item_t rand_query(input int active);
		star_item_t it;
		int k;
		it.cmd = CMD_QUERY;
		it.idx = 10'($urandom_range(0, TABLE_SIZE - 1));
		it.px = rand_coord();
		it.py = rand_coord();
		it.pz = rand_coord();
		// sit on an active star now and then
		if ($urandom_range(0, 9) < 3) begin
			k = $urandom_range(0, active - 1);
			it.px = tab_px[k];
			it.py = tab_py[k];
			it.pz = tab_pz[k];
		end
		it.m = $urandom;
		it.vx = $urandom;
		it.vy = $urandom;
		it.vz = $urandom;
		return it;
	endfunction

	initial begin
		dir_row_t dir_rows[$];
		dir_row_t r;
		force_res_t no_lit;
		int active;
		no_lit = '{default: '0};

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty sum, kinetic clip, zero distance, huge pull, extremes
		dir_rows.push_back(cfg_row(REG_STAR_COUNT, 32'd0));
		r = query_row(32'h0, 32'h0, 32'h0, Q_ONE, 32'h0, 32'h0);
		r.has_lit = 1'b1;
		r.lit = '{64'h0, 64'h0, 64'h0, 64'h8000_0000, 1'b0};
		dir_rows.push_back(r);
		dir_rows.push_back(cfg_row(REG_TEST_MASS, 32'hFFFF_FFFF));
		r = query_row(32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		r.has_lit = 1'b1;
		r.lit = '{64'h0, 64'h0, 64'h0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1};
		dir_rows.push_back(r);
		dir_rows.push_back(cfg_row(REG_TEST_MASS, Q_ONE));
		dir_rows.push_back(load_row(10'd0, Q_ONE, 32'h0002_0000, 32'hFFFD_0000, Q_ONE));
		dir_rows.push_back(load_row(10'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'hFFFF_FFFF));
		dir_rows.push_back(load_row(10'd1023, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'hFFFF_FFFF));
		dir_rows.push_back(cfg_row(REG_STAR_COUNT, 32'd1));
		r = query_row(Q_ONE, 32'h0002_0000, 32'hFFFD_0000, 32'h0, 32'h0, 32'h0);
		r.has_lit = 1'b1;
		r.lit = '{64'h0, 64'h0, 64'h0, 64'h0, 1'b0};
		dir_rows.push_back(r);
		dir_rows.push_back(query_row(32'h0, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0002_0000,
			32'h0003_0000));
		dir_rows.push_back(cfg_row(REG_GRAV_TIMES_TEST_MASS, 32'hFFFF_FFFF));
		dir_rows.push_back(query_row(32'h0001_0001, 32'h0002_0000, 32'hFFFD_0000,
			32'h7FFF_FFFF, 32'h0, 32'h8000_0000));
		dir_rows.push_back(cfg_row(REG_STAR_COUNT, 32'd2));
		dir_rows.push_back(query_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
		dir_rows.push_back(cfg_row(REG_GRAV_TIMES_TEST_MASS, 32'h0));
		dir_rows.push_back(query_row(32'h1234_5678, 32'hEDCB_A988, 32'h0F0F_0F0F,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF));
		dir_rows.push_back(cfg_row(REG_SPARE, 32'hFFFF_FFFF));
		dir_rows.push_back(cfg_row(REG_GRAV_TIMES_TEST_MASS, Q_ONE));
		dir_rows.push_back(query_row(32'h0000_8000, 32'hFFFF_8000, 32'h0, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF));
		dir_rows.push_back(load_row(10'd0, 32'h0, 32'h0, 32'h0003_0000, 32'h0));
		dir_rows.push_back(query_row(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg)
				write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
			else
				offer_item(dir_rows[i].it, dir_rows[i].has_lit, dir_rows[i].lit);
		end

		// Load every entry that the random phases can sum over
		for (int i = 0; i < PRELOAD_STARS; i++) begin
			r.it = rand_load(0);
			r.it.idx = 10'(i);
			offer_item(r.it, 1'b0, no_lit);
		end

		// Random phases over small active sets and varied masses
		for (int ph = 0; ph < 8; ph++) begin
			active = (ph == 0) ? 1 : $urandom_range(1, PRELOAD_STARS);
			write_reg(REG_STAR_COUNT, 32'(active));
			write_reg(REG_GRAV_TIMES_TEST_MASS, rand_reg_mass());
			write_reg(REG_TEST_MASS, rand_reg_mass());
			if (ph == 3)
				hold_go = 1'b1;
			for (int k = 0; k < 70; k++) begin
				if ($urandom_range(0, 9) < 4)
					offer_item(rand_query(active), 1'b0, no_lit);
				else
					offer_item(rand_load(active + 1), 1'b0, no_lit);
			end
		end

		// Drain and let the block settle
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_forces.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* sim.f */
+incdir+sv
sv/dsgf_pkg.sv
sv/dsgf_div.sv
sv/dsgf_isqrt.sv
sv/direct_sum_gravity_force.sv
bench/direct_sum_gravity_force_tb.sv
